FILE: rtl/core/sudiv_pkg.sv
package sudiv_pkg;

  // Default and supported operand width of the divider core.
  localparam int DATA_WIDTH_DEF = 64;

  // Fixed field widths on the stream ports.
  localparam int OPCODE_W    = 2;
  localparam int FIELD_W     = 64;
  localparam int IN_TDATA_W  = 2 * FIELD_W;
  localparam int OUT_TDATA_W = FIELD_W;
  localparam int OUT_TUSER_W = 1;

  // Operation codes carried in the input tuser.
  typedef enum logic [OPCODE_W-1:0] {
    OP_UDIV = 2'd0,
    OP_UREM = 2'd1,
    OP_SDIV = 2'd2,
    OP_SREM = 2'd3
  } opcode_t;

  // Per-item control that rides along the pipeline next to the data.
  typedef struct packed {
    logic want_rem;  // deliver the remainder instead of the quotient
    logic neg_res;   // negate the selected result at the end
    logic dbz;       // divisor was zero, result forced to zero
  } ctrl_t;

endpackage

FILE: rtl/core/sudiv_prep.sv
module sudiv_prep #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [sudiv_pkg::OPCODE_W-1:0] opcode,
  input  logic [sudiv_pkg::FIELD_W-1:0]  dividend,
  input  logic [sudiv_pkg::FIELD_W-1:0]  divisor,
  output logic                         out_valid,
  output sudiv_pkg::ctrl_t             out_ctrl,
  output logic [DATA_WIDTH-1:0]        out_num,
  output logic [DATA_WIDTH-1:0]        out_den
);
  import sudiv_pkg::*;

  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic                  is_signed;
  logic                  want_rem;
  logic                  sa;
  logic                  sb;
  logic [DATA_WIDTH-1:0] ua;
  logic [DATA_WIDTH-1:0] ub;
  ctrl_t                 ctrl_next;

  // Decode the operation and take the operand magnitudes.
  always_comb begin
    a         = dividend[DATA_WIDTH-1:0];
    b         = divisor[DATA_WIDTH-1:0];
    is_signed = (opcode == OP_SDIV) || (opcode == OP_SREM);
    want_rem  = (opcode == OP_UREM) || (opcode == OP_SREM);
    sa        = is_signed & a[DATA_WIDTH-1];
    sb        = is_signed & b[DATA_WIDTH-1];
    ua        = sa ? (~a + 1'b1) : a;
    ub        = sb ? (~b + 1'b1) : b;
    ctrl_next.want_rem = want_rem;
    ctrl_next.neg_res  = want_rem ? sa : (sa ^ sb);
    ctrl_next.dbz      = (b == '0);
  end

  // Valid bit under reset; payload loads whenever the pipe moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctrl <= ctrl_next;
      out_num  <= ua;
      out_den  <= ub;
    end
  end

endmodule

FILE: rtl/core/sudiv_stage.sv
module sudiv_stage #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  sudiv_pkg::ctrl_t      in_ctrl,
  input  logic [DATA_WIDTH-1:0] in_rem,
  input  logic [DATA_WIDTH-1:0] in_nq,
  input  logic [DATA_WIDTH-1:0] in_den,
  output logic                  out_valid,
  output sudiv_pkg::ctrl_t      out_ctrl,
  output logic [DATA_WIDTH-1:0] out_rem,
  output logic [DATA_WIDTH-1:0] out_nq,
  output logic [DATA_WIDTH-1:0] out_den
);
  import sudiv_pkg::*;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] nq_next;

  // One restoring step: shift in the next dividend bit, trial subtract.
  // The dividend bits leave nq from the top while quotient bits enter
  // at the bottom.
  always_comb begin
    shifted  = {in_rem, in_nq[DATA_WIDTH-1]};
    diff     = {1'b0, shifted} - {2'b00, in_den};
    qbit     = ~diff[DATA_WIDTH+1];
    rem_next = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    nq_next  = {in_nq[DATA_WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctrl <= in_ctrl;
      out_rem  <= rem_next;
      out_nq   <= nq_next;
      out_den  <= in_den;
    end
  end

endmodule

FILE: rtl/core/sudiv_post.sv
module sudiv_post #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  sudiv_pkg::ctrl_t              in_ctrl,
  input  logic [DATA_WIDTH-1:0]         in_rem,
  input  logic [DATA_WIDTH-1:0]         in_quo,
  output logic                          out_valid,
  output logic [sudiv_pkg::FIELD_W-1:0] out_result,
  output logic                          out_dbz
);
  import sudiv_pkg::*;

  logic [DATA_WIDTH-1:0] sel;
  logic [DATA_WIDTH-1:0] fixed;
  logic [FIELD_W-1:0]    result_next;

  // Pick quotient or remainder, restore the sign, force zero on a zero divisor.
  always_comb begin
    sel         = in_ctrl.want_rem ? in_rem : in_quo;
    fixed       = in_ctrl.neg_res ? (~sel + 1'b1) : sel;
    result_next = in_ctrl.dbz ? '0 : FIELD_W'(fixed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result <= result_next;
      out_dbz    <= in_ctrl.dbz;
    end
  end

endmodule

FILE: rtl/core/sudiv_skid.sv
module sudiv_skid #(
  parameter int WIDTH = 65
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;

  // Ready is a register: it drops only once the spare entry is in use.
  assign in_ready = ~skid_valid;

  // Output register plus one spare entry that catches a transfer
  // arriving while the output is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

FILE: rtl/core/signed_unsigned_divider_64_unit.sv
// Pipelined signed and unsigned integer divider.
//
// Input stream: s_axis_tdata carries the dividend (bits 63:0) and the
// divisor (bits 127:64); s_axis_tuser carries the opcode: unsigned
// quotient, unsigned remainder, signed quotient or signed remainder.
// Only the low DATA_WIDTH bits of each operand are used.
// Output stream: m_axis_tdata carries the result, zero above DATA_WIDTH;
// m_axis_tuser[0] is set when the divisor was zero, the result is then 0.
//
// Throughput is one transfer per cycle while the output is not stalled. Each
// item passes an operand conditioning stage, DATA_WIDTH restoring-division
// stages (one quotient bit per stage), a sign fix-up stage and the output
// register, in that order.
// Reset (rst, synchronous) empties the pipeline; all valid bits clear.
// When the receiver stalls, the output register holds its result and the
// pipeline moves one more transfer into a spare entry; s_axis_tready then
// drops and the whole pipeline holds until the output is taken.
module signed_unsigned_divider_64_unit #(
  parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sudiv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // dividend, divisor
  input  logic [sudiv_pkg::OPCODE_W-1:0]    s_axis_tuser,  // opcode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sudiv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // result
  output logic [sudiv_pkg::OUT_TUSER_W-1:0] m_axis_tuser   // divide_by_zero
);
  import sudiv_pkg::*;

  logic                  en;
  logic                  valid_s [0:DATA_WIDTH];
  ctrl_t                 ctrl_s  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_s   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nq_s    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den_s   [0:DATA_WIDTH];
  logic                  post_valid;
  logic [FIELD_W-1:0]    post_result;
  logic                  post_dbz;
  logic [FIELD_W:0]      out_data;

  // Operand conditioning; the partial remainder starts at zero.
  sudiv_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .opcode    (s_axis_tuser),
    .dividend  (s_axis_tdata[FIELD_W-1:0]),
    .divisor   (s_axis_tdata[IN_TDATA_W-1:FIELD_W]),
    .out_valid (valid_s[0]),
    .out_ctrl  (ctrl_s[0]),
    .out_num   (nq_s[0]),
    .out_den   (den_s[0])
  );

  assign rem_s[0] = '0;

  // One stage per quotient bit, most significant first.
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
    sudiv_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid_s[i]),
      .in_ctrl   (ctrl_s[i]),
      .in_rem    (rem_s[i]),
      .in_nq     (nq_s[i]),
      .in_den    (den_s[i]),
      .out_valid (valid_s[i+1]),
      .out_ctrl  (ctrl_s[i+1]),
      .out_rem   (rem_s[i+1]),
      .out_nq    (nq_s[i+1]),
      .out_den   (den_s[i+1])
    );
  end

  // Sign restore and zero-divisor handling.
  sudiv_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (valid_s[DATA_WIDTH]),
    .in_ctrl    (ctrl_s[DATA_WIDTH]),
    .in_rem     (rem_s[DATA_WIDTH]),
    .in_quo     (nq_s[DATA_WIDTH]),
    .out_valid  (post_valid),
    .out_result (post_result),
    .out_dbz    (post_dbz)
  );

  // Output register with a spare entry; its ready moves the whole pipe.
  sudiv_skid #(.WIDTH(FIELD_W + 1)) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (post_valid),
    .in_ready  (en),
    .in_data   ({post_dbz, post_result}),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign s_axis_tready = en;
  assign m_axis_tdata  = out_data[FIELD_W-1:0];
  assign m_axis_tuser  = out_data[FIELD_W +: OUT_TUSER_W];

endmodule

FILE: rtl/core/sudiv_checker.sv
module sudiv_checker #(
  parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [sudiv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [sudiv_pkg::OPCODE_W-1:0]    s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sudiv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [sudiv_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import sudiv_pkg::*;

  logic [OUT_TDATA_W-1:0] upper_mask;

  // Bits of the result above the operand width.
  assign upper_mask = ~(OUT_TDATA_W'({DATA_WIDTH{1'b1}}));

  // A stalled result holds until the transfer completes.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A zero divisor always yields a zero result.
  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("divide by zero with nonzero result");

  // Results never carry bits above the operand width.
  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata & upper_mask) == '0)
    else $error("result bits above the operand width are set");

  // Input back-pressure only appears while a result is waiting.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled output");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

endmodule

bind signed_unsigned_divider_64_unit sudiv_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sudiv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
